/* sv/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b at the same edge
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// a implies b at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

/* sv/aesctr_pkg.sv */
// shared types, constants and functions of the aes-128 counter-mode unit
`default_nettype none
package aesctr_pkg;
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;
	localparam logic [4:0] FULL_BYTES = 5'd16;
	localparam logic [31:0] CTR_INIT = 32'd2;
	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] iv_high;
		logic [63:0] iv_low;
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic [4:0]  byte_count;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic [4:0]  result_bytes;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic key_start;
		logic key_step;
		logic load_iv;
		logic blk_init;
		logic blk_round;
		logic blk_last;
		logic blk_finish;
	} cmd_t;

	typedef struct packed {
		logic [3:0] round;
	} status_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		unique case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* sv/aesctr_ctrl.sv */
// controller state machine of the counter-mode unit
`default_nettype none
module aesctr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 in_fire,
	input  wire logic                 in_kind,
	input  wire logic [4:0]           in_count,
	input  wire logic                 out_free,
	input  wire aesctr_pkg::status_t  sts,
	output aesctr_pkg::cmd_t          cmd,
	output logic                      busy
);
	import aesctr_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_KEY, S_ENC, S_DONE} state_t;
	state_t state_q;
	logic   key_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_pend_q <= 1'b1;
		end else begin
			if (cfg_we) key_pend_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (key_pend_q) begin
						state_q    <= S_KEY;
						key_pend_q <= cfg_we;
					end else if (in_fire && in_kind == KIND_DATA && in_count != 5'd0) begin
						state_q <= S_ENC;
					end
				end
				S_KEY: begin
					if (sts.round == 4'd10) state_q <= S_IDLE;
				end
				S_ENC: begin
					if (sts.round == 4'd10) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.key_start  = state_q == S_IDLE && key_pend_q;
		cmd.key_step   = state_q == S_KEY && sts.round != 4'd10;
		cmd.load_iv    = in_fire && in_kind == KIND_START;
		cmd.blk_init   = state_q == S_IDLE && !key_pend_q && in_fire
			&& in_kind == KIND_DATA && in_count != 5'd0;
		cmd.blk_round  = state_q == S_ENC && sts.round != 4'd10;
		cmd.blk_last   = state_q == S_ENC && sts.round == 4'd9;
		cmd.blk_finish = state_q == S_DONE && out_free;
	end

	assign busy = state_q != S_IDLE || key_pend_q;
endmodule
`default_nettype wire

/* sv/aesctr_dp.sv */
// key schedule, round datapath, counter and output register
`default_nettype none
module aesctr_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [63:0]           cfg_data,
	input  wire aesctr_pkg::in_item_t  in_item,
	input  wire aesctr_pkg::cmd_t      cmd,
	output aesctr_pkg::status_t        sts,
	output aesctr_pkg::out_item_t      out_item,
	output logic                       out_valid,
	input  wire logic                  out_ready
);
	import aesctr_pkg::*;

	logic [127:0] key_q;
	logic [127:0] rk_q [11];
	logic [127:0] kw_q;
	logic [3:0]   kr_q;
	logic [3:0]   br_q;
	logic [31:0]  nu_q;
	logic [63:0]  nl_q;
	logic [31:0]  ctr_q;
	logic [127:0] st_q;
	logic [127:0] data_q;
	logic [4:0]   cnt_q;
	logic         busy_enc_q;
	logic [127:0] knext;
	logic [127:0] rnd;
	logic [127:0] sb;
	logic [127:0] sr;
	logic [127:0] mc;
	logic [127:0] ks;
	logic [127:0] res;
	logic [31:0]  t;
	logic [4:0]   n;

	// next round key from the current one
	always_comb begin
		t = {sbox(kw_q[23:16]) ^ rcon(kr_q + 4'd1), sbox(kw_q[15:8]),
			sbox(kw_q[7:0]), sbox(kw_q[31:24])};
		knext[127:96] = kw_q[127:96] ^ t;
		knext[95:64]  = kw_q[95:64] ^ knext[127:96];
		knext[63:32]  = kw_q[63:32] ^ knext[95:64];
		knext[31:0]   = kw_q[31:0] ^ knext[63:32];
	end

	// one round; byte i sits at bits 127-8i
	always_comb begin
		for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = sbox(st_q[127-8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sr[127-8*(4*c+r) -: 8] = sb[127-8*(4*((c+r)%4)+r) -: 8];
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sr[127-32*c -: 8];
			a1 = sr[119-32*c -: 8];
			a2 = sr[111-32*c -: 8];
			a3 = sr[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		rnd = (br_q == 4'd9 ? sr : mc) ^ rk_q[br_q + 4'd1];
	end

	always_comb begin
		n  = cnt_q > FULL_BYTES ? FULL_BYTES : cnt_q;
		ks = st_q ^ data_q;
		for (int i = 0; i < 16; i++)
			res[127-8*i -: 8] = (5'(i) < n) ? ks[127-8*i -: 8] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			kw_q       <= '0;
			kr_q       <= '0;
			br_q       <= 4'd10;
			nu_q       <= '0;
			nl_q       <= '0;
			ctr_q      <= CTR_INIT;
			out_valid  <= 1'b0;
			busy_enc_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_KEY_HIGH) key_q[127:64] <= cfg_data;
				else key_q[63:0] <= cfg_data;
			end
			if (cmd.key_start) begin
				kw_q     <= key_q;
				rk_q[0]  <= key_q;
				kr_q     <= '0;
			end else if (cmd.key_step) begin
				kw_q             <= knext;
				rk_q[kr_q + 4'd1] <= knext;
				kr_q             <= kr_q + 4'd1;
			end
			if (cmd.load_iv) begin
				nu_q  <= in_item.iv_high;
				nl_q  <= in_item.iv_low;
				ctr_q <= CTR_INIT;
			end
			if (cmd.blk_init) begin
				st_q       <= {nu_q, nl_q, ctr_q} ^ rk_q[0];
				data_q     <= {in_item.data_high, in_item.data_low};
				cnt_q      <= in_item.byte_count;
				br_q       <= '0;
				busy_enc_q <= 1'b1;
			end else if (cmd.blk_round) begin
				st_q <= rnd;
				br_q <= br_q + 4'd1;
			end
			if (cmd.blk_finish) begin
				out_item.result_high  <= res[127:64];
				out_item.result_low   <= res[63:0];
				out_item.result_bytes <= n;
				out_valid             <= 1'b1;
				ctr_q                 <= ctr_q + 32'd1;
				busy_enc_q            <= 1'b0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.round = busy_enc_q ? br_q : kr_q;
endmodule
`default_nettype wire

/* sv/aes128_counter_mode_cipher_unit.sv */
// top level of the aes-128 counter-mode cipher unit
// usage:
//  load the key through cfg_we / cfg_index / cfg_data (0 high half, 1 low half)
//  while idle; the eleven round keys are rebuilt, one per cycle
//  in the shared key-schedule unit, before the next transaction is taken.
//  an input transaction of kind start loads the iv and counter 2; no result.
//  a data transaction with a non-zero count gives one result transaction:
//  initial key addition plus ten rounds through one round unit, one per
//  cycle, then the result goes to the output register; the next block is
//  taken only once the last one has left the round unit.
//  bytes past the count are zero; count above 16 reads as 16.
//  reset loads the all-zero key schedule with counter 2.
//  a stalled receiver holds the result; a finished block waits in the
//  round unit until the output register frees, so input then waits too.
`default_nettype none
`include "assert_macros.svh"
module aes128_counter_mode_cipher_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [63:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire aesctr_pkg::in_item_t  in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output aesctr_pkg::out_item_t      out_item
);
	import aesctr_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    busy;
	logic    in_fire;
	logic    out_free;

	assign in_ready = !busy && !cfg_we;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	aesctr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .in_fire(in_fire),
		.in_kind(in_item.kind), .in_count(in_item.byte_count),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
	);

	aesctr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
	);

	`ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy, !in_ready)
	`ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.blk_finish, out_valid)
	`ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1,
		$onehot0({cmd.key_start, cmd.key_step, cmd.blk_init, cmd.blk_round, cmd.blk_finish}))
endmodule
`default_nettype wire
